[rtl/core/crtm_pkg.sv]
// Package with the beat types, constants and compare helpers of the counter reset table matcher.
`timescale 1ns / 1ps
package crtm_pkg;

  localparam int unsigned MaxEntriesDef = 64;
  localparam int unsigned NumCtrs       = 7;
  localparam int unsigned CtrW          = 64;
  localparam int unsigned IdxW          = 6;

  typedef enum logic [1:0] {
    CmdClear  = 2'd0,
    CmdAppend = 2'd1,
    CmdQuery  = 2'd2,
    CmdNone   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    StFound = 2'd0,
    StNew   = 2'd1,
    StRereg = 2'd2,
    StRsvd  = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]      cmd;
    logic [63:0]     name_high;
    logic [63:0]     name_low;
    logic [63:0]     rx_pkts;
    logic [63:0]     tx_pkts;
    logic [63:0]     rx_octets;
    logic [63:0]     tx_octets;
    logic [63:0]     rx_comp;
    logic [63:0]     tx_comp;
    logic [63:0]     mcast;
    logic [IdxW-1:0] start_pos;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [IdxW-1:0] match_index;
  } out_beat_t;

  // One table record as held in a cell.
  typedef struct packed {
    logic [63:0]              name_high;
    logic [63:0]              name_low;
    logic [NumCtrs-1:0][63:0] ctr;
  } rec_t;

  // String-like name compare: bytes matter up to the first zero byte of the current name.
  function automatic logic names_equal(input logic [127:0] cur, input logic [127:0] ref_n);
    logic eq;
    logic done;
    eq   = 1'b1;
    done = 1'b0;
    for (int i = 0; i < 16; i++) begin
      if (!done) begin
        if (cur[127-8*i -: 8] != ref_n[127-8*i -: 8]) begin
          eq   = 1'b0;
          done = 1'b1;
        end else if (cur[127-8*i -: 8] == 8'd0) begin
          done = 1'b1;
        end
      end
    end
    return eq;
  endfunction

endpackage

[rtl/core/counter_reset_table_matcher_top.sv]
// Top level of the counter reset table matcher: cell chain, sequencer and output register.
`timescale 1ns / 1ps
// The table lives in a ring of MaxEntries cells that holds the records in
// append order. A query on an empty table answers new interface in the
// next cycle. Any other query rotates the whole ring once, one cell per
// cycle, and tests the record passing the head cell; a hit at or after the
// clamped start entry wins over a hit before it, which gives the result of
// the circular search. The scan always covers the full ring, whatever the
// table holds; the output state then follows, and the result waits in an
// output register; no new beat is taken while a query runs or until the
// result beat has left.
module counter_reset_table_matcher_top #(
  parameter int unsigned MaxEntries = crtm_pkg::MaxEntriesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  crtm_pkg::in_beat_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output crtm_pkg::out_beat_t out_data_o
);

  localparam int unsigned CntW = $clog2(MaxEntries + 1);
  localparam int unsigned PosW = $clog2(MaxEntries);
  localparam int unsigned CmpW = CntW + crtm_pkg::IdxW;

  typedef enum logic [2:0] {
    SIdle = 3'b001,
    SScan = 3'b010,
    SOut  = 3'b100
  } state_e;

  state_e         state_q, state_d;
  logic [CntW-1:0] count_q;
  logic [CntW-1:0] rot_q;     // total rotation done in this query
  logic [PosW-1:0] head_q;    // table index now at the head cell
  logic [PosW-1:0] start_q;
  logic            found_q;     // some hit has been recorded
  logic            found_hi_q;  // a hit at or after the start entry has been recorded
  crtm_pkg::rec_t  cur_q;
  crtm_pkg::out_beat_t res_q;
  logic            out_valid_q;

  crtm_pkg::rec_t chain [MaxEntries];
  logic           shift_en;
  logic           match, rereg;
  crtm_pkg::rec_t in_rec;

  assign in_rec.name_high = in_data_i.name_high;
  assign in_rec.name_low  = in_data_i.name_low;
  assign in_rec.ctr = {in_data_i.mcast, in_data_i.tx_comp, in_data_i.rx_comp,
                       in_data_i.tx_octets, in_data_i.rx_octets,
                       in_data_i.tx_pkts, in_data_i.rx_pkts};

  logic in_acc;
  assign in_ready_o = (state_q == SIdle) && !out_valid_q;
  assign in_acc     = in_valid_i && in_ready_o;

  // Rotation moves the cell ring by one toward the head, in table order.
  for (genvar g = 0; g < MaxEntries; g++) begin : g_cell
    logic wr;
    assign wr = in_acc && (in_data_i.cmd == crtm_pkg::CmdAppend) &&
                (count_q < CntW'(MaxEntries)) && (count_q[PosW-1:0] == PosW'(g));
    crtm_cell u_cell (
      .clk_i      (clk_i),
      .wr_i       (wr),
      .wr_rec_i   (in_rec),
      .shift_i    (chain[(g + 1) % MaxEntries]),
      .shift_en_i (shift_en),
      .rec_o      (chain[g])
    );
  end

  crtm_judge u_judge (
    .cur_i   (cur_q),
    .ref_i   (chain[0]),
    .match_o (match),
    .rereg_o (rereg)
  );

  // Entries below the start come first in the lap; the first hit at or after
  // the start replaces any of them, later hits are ignored.
  logic head_hi, test_now, rec_now;
  assign shift_en = (state_q == SScan) && (rot_q != CntW'(MaxEntries));
  assign head_hi  = (head_q >= start_q);
  assign test_now = shift_en && (CntW'(head_q) < count_q) &&
                    (head_hi ? !found_hi_q : !found_q);
  assign rec_now  = test_now && match;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SIdle: if (in_acc && in_data_i.cmd == crtm_pkg::CmdQuery && count_q != '0) state_d = SScan;
      SScan: if (rot_q == CntW'(MaxEntries)) state_d = SOut;
      SOut:  state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      rot_q       <= '0;
      head_q      <= '0;
      found_q     <= 1'b0;
      found_hi_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (in_acc) begin
        case (in_data_i.cmd)
          crtm_pkg::CmdClear: count_q <= '0;
          crtm_pkg::CmdAppend: if (count_q < CntW'(MaxEntries)) count_q <= count_q + 1'b1;
          crtm_pkg::CmdQuery: begin
            rot_q      <= '0;
            head_q     <= '0;
            found_q    <= 1'b0;
            found_hi_q <= 1'b0;
            if (count_q == '0) out_valid_q <= 1'b1;
          end
          default: ;
        endcase
      end
      if (shift_en) begin
        rot_q  <= rot_q + 1'b1;
        head_q <= (head_q == PosW'(MaxEntries - 1)) ? '0 : head_q + 1'b1;
      end
      if (rec_now) begin
        found_q <= 1'b1;
        if (head_hi) found_hi_q <= 1'b1;
      end
      if (state_q == SOut) out_valid_q <= 1'b1;
    end
  end

  logic [crtm_pkg::IdxW-1:0] hit_idx;
  assign hit_idx = crtm_pkg::IdxW'(head_q);

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cur_q   <= in_rec;
      start_q <= (CmpW'(in_data_i.start_pos) >= CmpW'(count_q))
                 ? PosW'(count_q - 1'b1) : PosW'(in_data_i.start_pos);
      res_q.status      <= crtm_pkg::StNew;
      res_q.match_index <= '0;
    end else if (rec_now) begin
      if (rereg) begin
        res_q.status      <= crtm_pkg::StRereg;
        res_q.match_index <= '0;
      end else begin
        res_q.status      <= crtm_pkg::StFound;
        res_q.match_index <= hit_idx;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = res_q;

  // The block takes no beat while a result waits.
  a_no_in_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !in_ready_o) else $error("input taken while result pending");
  // The table never holds more than its capacity.
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxEntries)) else $error("entry count overflow");
  // A scan ends in the output state.
  a_scan_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SScan && rot_q == CntW'(MaxEntries)) |=> state_q == SOut)
    else $error("scan did not finish");

endmodule

[rtl/core/crtm_cell.sv]
// One table cell: holds a record and hands it to its neighbour while the ring rotates.
`timescale 1ns / 1ps
module crtm_cell (
  input  logic          clk_i,
  input  logic          wr_i,
  input  crtm_pkg::rec_t wr_rec_i,
  input  crtm_pkg::rec_t shift_i,
  input  logic          shift_en_i,
  output crtm_pkg::rec_t rec_o
);

  crtm_pkg::rec_t rec_q;

  // Appends land in the cell; during a query the chain rotates by one cell each cycle.
  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      rec_q <= wr_rec_i;
    end else if (shift_en_i) begin
      rec_q <= shift_i;
    end
  end

  assign rec_o = rec_q;

endmodule

[rtl/core/crtm_judge.sv]
// Name match and counter decrease judgement for the record at the head of the chain.
`timescale 1ns / 1ps
module crtm_judge (
  input  crtm_pkg::rec_t cur_i,
  input  crtm_pkg::rec_t ref_i,
  output logic          match_o,
  output logic          rereg_o
);

  logic [crtm_pkg::NumCtrs-1:0] lt, gt;
  logic dec, ovf;
  logic [63:0] half_max;

  assign half_max = {1'b0, {63{1'b1}}};

  always_comb begin
    for (int k = 0; k < crtm_pkg::NumCtrs; k++) begin
      lt[k] = cur_i.ctr[k] < ref_i.ctr[k];
      gt[k] = cur_i.ctr[k] > ref_i.ctr[k];
    end
    dec = |lt;
    // Packet/octet wrap on rx or tx excuses a decrease.
    ovf = (lt[2] && gt[0] && (ref_i.ctr[2] > half_max)) ||
          (lt[3] && gt[1] && (ref_i.ctr[3] > half_max)) ||
          (lt[0] && gt[2] && (ref_i.ctr[0] > half_max)) ||
          (lt[1] && gt[3] && (ref_i.ctr[1] > half_max));
  end

  assign match_o = crtm_pkg::names_equal({cur_i.name_high, cur_i.name_low},
                                         {ref_i.name_high, ref_i.name_low});
  assign rereg_o = dec && !ovf;

endmodule
